// ===== design/maf_pkg.sv =====
`timescale 1ns / 1ps

package maf_pkg;

    localparam int MAX_WINDOW   = 256;
    localparam int SAMPLE_BITS  = 16;
    localparam int PTR_BITS     = $clog2(MAX_WINDOW);
    localparam int WIDTH_BITS   = PTR_BITS + 1;
    localparam int SUM_BITS     = SAMPLE_BITS + PTR_BITS;
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_LAUNCH,
        S_DIV,
        S_STORE
    } state_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic pend_any;
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

// ===== design/maf_divider.sv =====
`timescale 1ns / 1ps

module maf_divider
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic signed [maf_pkg::SUM_BITS-1:0]      dividend,
    input  logic        [maf_pkg::WIDTH_BITS-1:0]    divisor,
    output logic                                     done,
    output logic signed [maf_pkg::SAMPLE_BITS-1:0]   quotient
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [maf_pkg::DIV_CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [maf_pkg::SUM_BITS-1:0]       quo_reg, quo_next;
    logic [maf_pkg::WIDTH_BITS-1:0]     rem_reg, rem_next;
    logic [maf_pkg::WIDTH_BITS-1:0]     div_reg, div_next;
    logic                               neg_reg, neg_next;
    logic [maf_pkg::WIDTH_BITS:0]       rem_shift;
    logic [maf_pkg::WIDTH_BITS:0]       rem_diff;
    logic                               fits;
    logic [maf_pkg::SUM_BITS-1:0]       magnitude;
    logic [maf_pkg::SAMPLE_BITS-1:0]    quo_low;

    assign magnitude = dividend[maf_pkg::SUM_BITS-1] ? maf_pkg::SUM_BITS'(-dividend)
                                                     : maf_pkg::SUM_BITS'(dividend);

    // one quotient bit per cycle, restoring form on the magnitude
    assign rem_shift = {rem_reg, quo_reg[maf_pkg::SUM_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign fits      = (rem_shift >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = magnitude;
            rem_next  = '0;
            div_next  = divisor;
            neg_next  = dividend[maf_pkg::SUM_BITS-1];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_diff[maf_pkg::WIDTH_BITS-1:0]
                            : rem_shift[maf_pkg::WIDTH_BITS-1:0];
            quo_next = {quo_reg[maf_pkg::SUM_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == maf_pkg::DIV_CNT_BITS'(maf_pkg::SUM_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    // the average always fits the sample width, so drop the upper bits
    assign quo_low  = quo_reg[maf_pkg::SAMPLE_BITS-1:0];
    assign quotient = neg_reg ? maf_pkg::SAMPLE_BITS'(-quo_low) : quo_low;
    assign done     = done_reg;

endmodule

// ===== design/maf_datapath.sv =====
`timescale 1ns / 1ps

module maf_datapath
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  maf_pkg::cmd_t                            cmd,
    output maf_pkg::status_t                         status,
    input  logic                                     cfg_write,
    input  logic        [maf_pkg::WIDTH_BITS-1:0]    cfg_data,
    input  logic signed [maf_pkg::SAMPLE_BITS-1:0]   sample,
    input  logic                                     first,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [maf_pkg::SAMPLE_BITS-1:0]   average,
    output logic                                     last_of_run
);

    logic        [maf_pkg::SAMPLE_BITS-1:0]  ring [maf_pkg::MAX_WINDOW];
    logic        [maf_pkg::SAMPLE_BITS-1:0]  rd_data_reg;
    logic        [maf_pkg::PTR_BITS-1:0]     rd_addr;

    logic        [maf_pkg::WIDTH_BITS-1:0]   width_reg, width_next;
    logic signed [maf_pkg::SUM_BITS-1:0]     sum_reg, sum_next;
    logic signed [maf_pkg::SUM_BITS-1:0]     old_sum_reg, old_sum_next;
    logic        [maf_pkg::WIDTH_BITS-1:0]   seen_reg, seen_next;
    logic        [maf_pkg::PTR_BITS-1:0]     pos_reg, pos_next;
    logic        [maf_pkg::SAMPLE_BITS-1:0]  sample_reg, sample_next;
    logic                                    pend_old_reg, pend_old_next;
    logic                                    pend_new_reg, pend_new_next;
    logic                                    out_valid_reg, out_valid_next;
    logic        [maf_pkg::SAMPLE_BITS-1:0]  average_reg, average_next;
    logic                                    last_reg, last_next;

    logic        [maf_pkg::WIDTH_BITS-1:0]   width_clamped;
    logic        [maf_pkg::PTR_BITS-1:0]     pos_start;
    logic                                    full_window;
    logic signed [maf_pkg::SUM_BITS-1:0]     sample_ext;
    logic signed [maf_pkg::SUM_BITS-1:0]     leaving_ext;
    logic signed [maf_pkg::SUM_BITS-1:0]     div_dividend;
    logic                                    div_done;
    logic signed [maf_pkg::SAMPLE_BITS-1:0]  div_quotient;

    // zero acts as one, anything beyond the ring acts as a full ring
    always_comb
    begin
        if (cfg_data == '0)
            width_clamped = maf_pkg::WIDTH_BITS'(1);
        else if (cfg_data > maf_pkg::WIDTH_BITS'(maf_pkg::MAX_WINDOW))
            width_clamped = maf_pkg::WIDTH_BITS'(maf_pkg::MAX_WINDOW);
        else
            width_clamped = cfg_data;
    end

    assign pos_start   = first ? '0 : pos_reg;
    // oldest sample of the window sits width slots behind the write slot
    assign rd_addr     = pos_start - width_reg[maf_pkg::PTR_BITS-1:0];
    assign full_window = (seen_reg >= width_reg);
    assign sample_ext  = maf_pkg::SUM_BITS'(signed'(sample_reg));
    assign leaving_ext = full_window ? maf_pkg::SUM_BITS'(signed'(rd_data_reg)) : '0;
    assign div_dividend = pend_old_reg ? old_sum_reg : sum_reg;

    always_comb
    begin
        width_next     = width_reg;
        sum_next       = sum_reg;
        old_sum_next   = old_sum_reg;
        seen_next      = seen_reg;
        pos_next       = pos_reg;
        sample_next    = sample_reg;
        pend_old_next  = pend_old_reg;
        pend_new_next  = pend_new_reg;
        out_valid_next = out_valid_reg;
        average_next   = average_reg;
        last_next      = last_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cfg_write)
        begin
            width_next = width_clamped;
            sum_next   = '0;
            seen_next  = '0;
            pos_next   = '0;
        end
        else if (cmd.accept)
        begin
            sample_next = sample;
            if (first)
            begin
                sum_next  = '0;
                seen_next = '0;
                pos_next  = '0;
            end
        end
        else if (cmd.update)
        begin
            old_sum_next  = sum_reg;
            sum_next      = sum_reg + sample_ext - leaving_ext;
            pos_next      = pos_reg + 1'b1;
            pend_old_next = (seen_reg == width_reg);
            pend_new_next = full_window;
            if ({1'b0, seen_reg} < ({1'b0, width_reg} + 1'b1))
                seen_next = seen_reg + 1'b1;
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            average_next   = div_quotient;
            last_next      = !pend_old_reg;
            if (pend_old_reg)
                pend_old_next = 1'b0;
            else
                pend_new_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= maf_pkg::WIDTH_BITS'(1);
            sum_reg       <= '0;
            seen_reg      <= '0;
            pos_reg       <= '0;
            pend_old_reg  <= 1'b0;
            pend_new_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            sum_reg       <= sum_next;
            seen_reg      <= seen_next;
            pos_reg       <= pos_next;
            pend_old_reg  <= pend_old_next;
            pend_new_reg  <= pend_new_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        old_sum_reg <= old_sum_next;
        sample_reg  <= sample_next;
        average_reg <= average_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            rd_data_reg <= ring[rd_addr];
        if (cmd.update)
            ring[pos_reg] <= sample_reg;
    end

    maf_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (width_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign status.pend_any = pend_old_reg || pend_new_reg;
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign average     = average_reg;
    assign last_of_run = last_reg;

endmodule

// ===== design/maf_controller.sv =====
`timescale 1ns / 1ps

module maf_controller
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  maf_pkg::status_t  status,
    output maf_pkg::cmd_t     cmd
);

    maf_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            maf_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = maf_pkg::S_UPDATE;
            end
            maf_pkg::S_UPDATE:
                state_next = maf_pkg::S_LAUNCH;
            maf_pkg::S_LAUNCH:
            begin
                if (status.pend_any)
                    state_next = maf_pkg::S_DIV;
                else
                    state_next = maf_pkg::S_IDLE;
            end
            maf_pkg::S_DIV:
            begin
                if (status.div_done)
                    state_next = maf_pkg::S_STORE;
            end
            maf_pkg::S_STORE:
            begin
                // hold the quotient until the output register frees up
                if (!status.out_busy)
                    state_next = maf_pkg::S_LAUNCH;
            end
            default:
                state_next = maf_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            maf_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            maf_pkg::S_UPDATE:
                cmd.update = 1'b1;
            maf_pkg::S_LAUNCH:
                cmd.div_start = status.pend_any;
            maf_pkg::S_DIV:
                cmd = '0;
            maf_pkg::S_STORE:
                cmd.out_load = !status.out_busy;
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= maf_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/moving_average_filter.sv =====
`timescale 1ns / 1ps

// Boxcar moving average over signed 16-bit samples.
// Input channel (in_valid/in_ready) carries one word: sample plus first flag;
// first = 1 starts a new list with that sample. Output channel
// (out_valid/out_ready) carries average and last_of_run. cfg_valid/cfg_ready
// writes the window length (0 acts as 1, above 256 acts as 256) and restarts
// the list; cfg_ready is always high, write it only while the block is quiet.
// No output until a list holds window length + 1 samples; that sample yields
// two words (first-window average with last_of_run = 0, then the newest one),
// every later sample yields one.
// Steps: a sample is taken in S_IDLE, folded into the sum and ring in
// S_UPDATE, then each average goes through a 24-step iterative divider
// (launch, 24 steps, done, then store, which waits while the output is
// stalled), and a closing launch finds no more work. The divider and a
// stalled receiver set the rate. The next sample is taken once the last
// average sits in the output register, even if the receiver has not taken
// it yet; a stalled receiver then holds the following result inside the
// block.
// Reset empties the list, sets the window length to 1 and clears the output.
module moving_average_filter
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic        [maf_pkg::WIDTH_BITS-1:0]    cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [maf_pkg::SAMPLE_BITS-1:0]   sample,
    input  logic                                     first,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [maf_pkg::SAMPLE_BITS-1:0]   average,
    output logic                                     last_of_run
);

    maf_pkg::cmd_t    cmd;
    maf_pkg::status_t status;

    assign cfg_ready = 1'b1;

    maf_controller u_controller
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    maf_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .sample      (sample),
        .first       (first),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .average     (average),
        .last_of_run (last_of_run)
    );

    // one sample at a time: no second word right after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && !out_ready))
        else $error("output register overwritten while stalled");

    // results only appear from a store command
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("output valid without a store");

endmodule

// ===== verif/maf_checker.sv =====
`timescale 1ns / 1ps

module maf_checker
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic        [maf_pkg::WIDTH_BITS-1:0]   cfg_data,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic signed [maf_pkg::SAMPLE_BITS-1:0]  sample,
    input  logic                                    first,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [maf_pkg::SAMPLE_BITS-1:0]  average,
    input  logic                                    last_of_run,
    output int                                      fail_count,
    output int                                      words_pending,
    output int                                      words_checked
);

    typedef struct packed {
        logic signed [maf_pkg::SAMPLE_BITS-1:0] average;
        logic                                   last_of_run;
    } avg_word_t;

    avg_word_t                              expected_averages[$];
    logic signed [maf_pkg::SAMPLE_BITS-1:0] window_ring [maf_pkg::MAX_WINDOW];
    longint                                 window_sum;
    int                                     list_len;
    int                                     write_pos;
    int                                     window_len;
    int                                     fails;
    int                                     checked;

    function automatic void restart_list();
        window_sum = 0;
        list_len   = 0;
        write_pos  = 0;
    endfunction

    function automatic void apply_window(input logic [maf_pkg::WIDTH_BITS-1:0] value);
        int w;
        w = value;
        if (w == 0)
            w = 1;
        if (w > maf_pkg::MAX_WINDOW)
            w = maf_pkg::MAX_WINDOW;
        window_len = w;
        restart_list();
    endfunction

    function automatic void predict_averages(
        input logic signed [maf_pkg::SAMPLE_BITS-1:0] x,
        input logic                                   new_list);
        longint    prior_sum;
        int        prior_len;
        int        slot;
        avg_word_t word;
        if (new_list)
            restart_list();
        prior_len = list_len;
        prior_sum = window_sum;
        // drop the sample leaving the window
        if (prior_len >= window_len)
        begin
            slot = (write_pos + maf_pkg::MAX_WINDOW - window_len) % maf_pkg::MAX_WINDOW;
            window_sum = window_sum - window_ring[slot];
        end
        window_sum = window_sum + x;
        window_ring[write_pos] = x;
        write_pos = (write_pos + 1) % maf_pkg::MAX_WINDOW;
        if (list_len < window_len + 1)
            list_len++;
        // held-back first window comes out ahead of the newest one
        if (prior_len == window_len)
        begin
            word.average     = prior_sum / longint'(window_len);
            word.last_of_run = 1'b0;
            expected_averages.push_back(word);
        end
        if (prior_len >= window_len)
        begin
            word.average     = window_sum / longint'(window_len);
            word.last_of_run = 1'b1;
            expected_averages.push_back(word);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        avg_word_t want;
        if (!rst_n)
        begin
            expected_averages.delete();
            window_len = 1;
            restart_list();
            fails   = 0;
            checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_averages.size() == 0)
                begin
                    $error("unexpected word: average=%0d last_of_run=%0b",
                           average, last_of_run);
                    fails++;
                end
                else
                begin
                    want = expected_averages.pop_front();
                    checked++;
                    if (average !== want.average)
                    begin
                        $error("average: expected %0d, got %0d", want.average, average);
                        fails++;
                    end
                    if (last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, last_of_run);
                        fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                apply_window(cfg_data);
            if (in_valid && in_ready)
                predict_averages(sample, first);
        end
        fail_count    <= fails;
        words_pending <= expected_averages.size();
        words_checked <= checked;
    end

endmodule

// ===== verif/tb_moving_average_filter.sv =====
`timescale 1ns / 1ps

module tb_moving_average_filter;

    localparam int RANDOM_SAMPLES = 1800;
    localparam int QUIET_CYCLES   = 60;
    localparam int CYCLE_LIMIT    = 1000000;

    logic                                   clk = 1'b0;
    logic                                   rst_n;
    logic                                   cfg_valid;
    logic                                   cfg_ready;
    logic        [maf_pkg::WIDTH_BITS-1:0]  cfg_data;
    logic                                   in_valid;
    logic                                   in_ready;
    logic signed [maf_pkg::SAMPLE_BITS-1:0] sample;
    logic                                   first;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic signed [maf_pkg::SAMPLE_BITS-1:0] average;
    logic                                   last_of_run;

    int fail_count;
    int words_pending;
    int words_checked;
    int cycles = 0;
    int samples_sent;
    int window_writes;
    int tx_idle_pct;
    int rx_idle_pct;

    moving_average_filter dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .first       (first),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .average     (average),
        .last_of_run (last_of_run)
    );

    maf_checker avg_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .first         (first),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .average       (average),
        .last_of_run   (last_of_run),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .words_checked (words_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[moving_average_filter] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rx_idle_pct);

    task automatic push_sample(input logic signed [maf_pkg::SAMPLE_BITS-1:0] value,
                               input logic new_list);
        in_valid <= 1'b1;
        sample   <= value;
        first    <= new_list;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        samples_sent++;
        // drop valid for a short gap now and then
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // write only once the block has drained and settled
    task automatic set_window(input logic [maf_pkg::WIDTH_BITS-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        window_writes++;
    endtask

    function automatic logic signed [maf_pkg::SAMPLE_BITS-1:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return maf_pkg::SAMPLE_BITS'($urandom);
        if (r < 85)
            return maf_pkg::SAMPLE_BITS'($urandom_range(40) - 20);
        return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endfunction

    initial
    begin
        int                                     random_sent;
        int                                     r;
        int                                     eff;
        int                                     seg_len;
        logic [maf_pkg::WIDTH_BITS-1:0]         w;
        logic                                   hold;
        logic signed [maf_pkg::SAMPLE_BITS-1:0] hold_val;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        sample        <= '0;
        first         <= 1'b0;
        samples_sent  = 0;
        window_writes = 0;
        tx_idle_pct   = 8;
        rx_idle_pct   = 53;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window of one out of reset: second sample brings two words
        push_sample(16'sd5, 1'b0);
        push_sample(-16'sd7, 1'b0);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sh8000, 1'b1);
        push_sample(-16'sd1, 1'b0);
        // zero acts as one
        set_window('0);
        push_sample(16'sd3, 1'b0);
        push_sample(16'sd4, 1'b0);
        push_sample(-16'sd3, 1'b0);
        // sums that do not divide evenly by three exercise truncation toward zero
        set_window(9'd3);
        push_sample(-16'sd5, 1'b0);
        push_sample(16'sd7, 1'b0);
        push_sample(16'sd2, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7fff, 1'b0);
        push_sample(16'sd9, 1'b1);
        push_sample(16'sd10, 1'b0);
        push_sample(-16'sd12, 1'b0);
        push_sample(16'sd13, 1'b0);
        push_sample(-16'sd2, 1'b0);
        // oversized window, then rewrite it partway through a list
        set_window(9'd511);
        push_sample(16'sd100, 1'b0);
        push_sample(-16'sd100, 1'b0);
        push_sample(16'sd1, 1'b0);
        set_window(9'd2);

        random_sent = 0;
        while (random_sent < RANDOM_SAMPLES)
        begin
            r = $urandom_range(99);
            if (r < 3)
                w = maf_pkg::WIDTH_BITS'($urandom_range(256, 511));
            else if (r < 6)
                w = '0;
            else if (r < 16)
                w = maf_pkg::WIDTH_BITS'($urandom_range(9, 40));
            else
                w = maf_pkg::WIDTH_BITS'($urandom_range(1, 8));
            set_window(w);
            eff = (w == 0) ? 1 : (w > maf_pkg::MAX_WINDOW) ? maf_pkg::MAX_WINDOW : w;
            seg_len = eff + 1 + ((eff > 40) ? $urandom_range(8) : $urandom_range(30));
            hold = ($urandom_range(99) < 15);
            hold_val = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            for (int i = 0; i < seg_len; i++)
            begin
                if (random_sent < RANDOM_SAMPLES / 3)
                begin
                    tx_idle_pct = 8;
                    rx_idle_pct = 53;
                end
                else if (random_sent < 2 * RANDOM_SAMPLES / 3)
                begin
                    tx_idle_pct = 53;
                    rx_idle_pct = 8;
                end
                else
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                push_sample(hold ? hold_val : pick_sample(),
                            (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 4));
                random_sent++;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);

        $display("Sent %0d samples across %0d window writes (1 to 256 and clamped values),",
                 samples_sent, window_writes);
        $display("checked %0d average words under three idle and stall mixes.",
                 words_checked);
        if (fail_count == 0 && words_pending == 0)
            $display("[moving_average_filter] OK");
        else
            $display("[moving_average_filter] ERROR");
        $finish;
    end

endmodule
